/* rtl/adz_pkg.sv */
// ----------------------------------------------------------------------------
// adz_pkg: shared types and constants for the axial / radial dead zone
// Sample format, mode and register codes, pipeline step counts.
// ----------------------------------------------------------------------------
package adz_pkg;

    localparam int SW          = 16;            // sample width, Q1.15
    localparam int SUM_W       = 2 * SW + 2;    // sum of four squares
    localparam int MAG_W       = SW + 1;        // root of the sum
    localparam int SQRT_STEPS  = SUM_W / 2;     // one root bit per stage
    localparam int RMP_STEPS   = SW - 1;        // remap quotient bits
    localparam int SCL_STEPS   = SW;            // radial scale quotient bits

    localparam logic [SW-1:0] FULL_SCALE = SW'(1) << (SW - 1);
    localparam logic [SW-1:0] OUT_MAX    = FULL_SCALE - SW'(1);

    localparam logic [2:0] MODE_DIGITAL = 3'd0;
    localparam logic [2:0] MODE_1D      = 3'd1;
    localparam logic [2:0] MODE_2D      = 3'd2;
    localparam logic [2:0] MODE_3D      = 3'd3;
    localparam logic [2:0] MODE_4D      = 3'd4;

    localparam logic [1:0] CFG_LOWER = 2'd0;
    localparam logic [1:0] CFG_UPPER = 2'd1;
    localparam logic [1:0] CFG_KIND  = 2'd2;

    localparam logic ZONE_AXIAL  = 1'b0;
    localparam logic ZONE_RADIAL = 1'b1;

    localparam logic [SW-1:0] LOWER_RST = SW'(6554);
    localparam logic [SW-1:0] UPPER_RST = FULL_SCALE;

    // per-sample control that travels down the pipe
    typedef struct packed {
        logic                 rad;   // scale by vector magnitude
        logic [3:0]           act;   // lanes that get remapped
        logic [3:0][SW-1:0]   raw;   // input values, x in lane 0
    } t_side;

endpackage

/* rtl/adz_sqrt.sv */
// ----------------------------------------------------------------------------
// adz_sqrt: pipelined integer square root
// Floor root of the sum of squares, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module adz_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [adz_pkg::SUM_W-1:0]   i_sum,
    output logic [adz_pkg::MAG_W-1:0]   o_root
);

    localparam int N   = adz_pkg::SQRT_STEPS;
    localparam int RW  = adz_pkg::MAG_W + 3;

    logic [RW-1:0]               r_rem  [N];
    logic [adz_pkg::MAG_W-1:0]   r_root [N];
    logic [adz_pkg::SUM_W-1:0]   r_num  [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [RW-1:0]               rem_in;
        logic [adz_pkg::MAG_W-1:0]   root_in;
        logic [adz_pkg::SUM_W-1:0]   num_in;
        logic [RW-1:0]               rem2;
        logic [RW-1:0]               trial;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign num_in  = i_sum;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign num_in  = r_num[k-1];
        end

        // bring down two bits, try (4r + 1)
        assign rem2  = {rem_in[RW-3:0], num_in[adz_pkg::SUM_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= {num_in[adz_pkg::SUM_W-3:0], 2'b00};
                if (rem2 >= trial) begin
                    r_rem[k]  <= rem2 - trial;
                    r_root[k] <= {root_in[adz_pkg::MAG_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= rem2;
                    r_root[k] <= {root_in[adz_pkg::MAG_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule

/* rtl/axial_radial_dead_zone.sv */
// ----------------------------------------------------------------------------
// axial_radial_dead_zone: dead zone remap of controller axis samples
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes a mode and four Q1.15 axis
// values; output channel (o_out_valid / i_out_ready) returns four remapped
// values, one result beat for every input beat, in order.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes lower threshold,
// upper threshold and zone kind by index; it is always ready and must only
// be used while the pipe is empty.
// Throughput: one sample per cycle while the receiver takes results. Depth is
// set by the 17-stage square root, the 15-stage remap divider and the
// 16-stage magnitude divider plus six stages of operand handling.
// Every stage advances together; when the output beat is held by the
// receiver the whole pipe holds and o_in_ready drops, nothing is lost.
// Reset clears the pipe valid bits and loads the register defaults
// (lower 6554, upper 32768, radial); there is no clearing pass.
// ----------------------------------------------------------------------------
module axial_radial_dead_zone (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [adz_pkg::SW-1:0]   i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_mode,
    input  logic signed [adz_pkg::SW-1:0] i_x_in,
    input  logic signed [adz_pkg::SW-1:0] i_y_in,
    input  logic signed [adz_pkg::SW-1:0] i_z_in,
    input  logic signed [adz_pkg::SW-1:0] i_w_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [adz_pkg::SW-1:0] o_x_out,
    output logic signed [adz_pkg::SW-1:0] o_y_out,
    output logic signed [adz_pkg::SW-1:0] o_z_out,
    output logic signed [adz_pkg::SW-1:0] o_w_out
);

    localparam int SW    = adz_pkg::SW;
    localparam int MW    = adz_pkg::MAG_W;
    localparam int S_SUM = 2;
    localparam int S_RT  = S_SUM + adz_pkg::SQRT_STEPS;
    localparam int S_PRE = S_RT + 1;
    localparam int S_RMP = S_PRE + adz_pkg::RMP_STEPS;
    localparam int S_MUL = S_RMP + 1;
    localparam int S_SCL = S_MUL + adz_pkg::SCL_STEPS;
    localparam int S_OUT = S_SCL + 1;
    localparam int NST   = S_OUT + 1;
    localparam int RN    = adz_pkg::RMP_STEPS;
    localparam int SN    = adz_pkg::SCL_STEPS;

    function automatic logic [SW-1:0] f_abs(input logic [SW-1:0] v);
        f_abs = v[SW-1] ? (~v + SW'(1)) : v;
    endfunction

    // configuration
    logic [SW-1:0] r_lower, r_upper;
    logic          r_kind;
    logic [SW-1:0] span;

    assign o_cfg_ready = 1'b1;
    assign span        = r_upper - r_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= adz_pkg::LOWER_RST;
            r_upper <= adz_pkg::UPPER_RST;
            r_kind  <= adz_pkg::ZONE_RADIAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                adz_pkg::CFG_LOWER: r_lower <= i_cfg_data;
                adz_pkg::CFG_UPPER: r_upper <= i_cfg_data;
                adz_pkg::CFG_KIND:  r_kind  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipe control
    logic               ce;
    logic [NST-1:0]     r_vld;
    adz_pkg::t_side     r_side [NST];
    adz_pkg::t_side     n_side;

    assign ce          = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready  = ce;
    assign o_out_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    always_comb begin
        n_side.raw = {i_w_in, i_z_in, i_y_in, i_x_in};
        n_side.rad = 1'b0;
        n_side.act = 4'b0000;
        case (i_mode)
            adz_pkg::MODE_1D: begin
                n_side.act = (r_kind == adz_pkg::ZONE_RADIAL) ? 4'b0001 : 4'b1111;
            end
            adz_pkg::MODE_2D: begin
                n_side.rad = (r_kind == adz_pkg::ZONE_RADIAL);
                n_side.act = n_side.rad ? 4'b0011 : 4'b1111;
            end
            adz_pkg::MODE_3D: begin
                n_side.rad = (r_kind == adz_pkg::ZONE_RADIAL);
                n_side.act = n_side.rad ? 4'b0111 : 4'b1111;
            end
            adz_pkg::MODE_4D: begin
                n_side.rad = (r_kind == adz_pkg::ZONE_RADIAL);
                n_side.act = 4'b1111;
            end
            default: ;  // digital and unused codes pass through
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[0] <= n_side;
            for (int k = 1; k < NST; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // magnitude: abs, squares, sum, root
    logic [3:0][SW-1:0]     r_abs;
    logic [3:0][2*SW-1:0]   r_sq;
    logic [adz_pkg::SUM_W-1:0] r_sum;
    logic [MW-1:0]          mag;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                r_abs[i] <= f_abs(n_side.raw[i]);
                r_sq[i]  <= (r_side[0].rad && r_side[0].act[i])
                            ? (2*SW)'(r_abs[i]) * (2*SW)'(r_abs[i]) : '0;
            end
            r_sum <= adz_pkg::SUM_W'(r_sq[0]) + adz_pkg::SUM_W'(r_sq[1])
                   + adz_pkg::SUM_W'(r_sq[2]) + adz_pkg::SUM_W'(r_sq[3]);
        end
    end

    adz_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (ce),
        .i_sum  (r_sum),
        .o_root (mag)
    );

    // remap set-up: classify each lane, form the excess
    logic [3:0][SW-1:0] r_prem;
    logic [3:0]         r_pzero, r_pfull;
    logic [MW-1:0]      r_pmag;

    always_ff @(posedge i_clk) begin
        logic [MW-1:0] m;
        logic [MW-1:0] ex;
        if (ce) begin
            r_pmag <= mag;
            for (int i = 0; i < 4; i++) begin
                m  = r_side[S_RT].rad ? mag : {1'b0, f_abs(r_side[S_RT].raw[i])};
                ex = m - {1'b0, r_lower};
                r_prem[i]  <= ex[SW-1:0];
                r_pzero[i] <= (m <= {1'b0, r_lower});
                r_pfull[i] <= (m > {1'b0, r_lower})
                              && ((r_upper <= r_lower) || (ex >= {1'b0, span}));
            end
        end
    end

    // remap divider: excess * 2^15 / span, one quotient bit per stage
    logic [3:0][SW-1:0]   r_rrem  [RN];
    logic [3:0][SW-2:0]   r_rq    [RN];
    logic [3:0]           r_rzero [RN];
    logic [3:0]           r_rfull [RN];
    logic [MW-1:0]        r_rmag  [RN];

    for (genvar k = 0; k < RN; k++) begin : g_rmp
        logic [3:0][SW-1:0] rem_in;
        logic [3:0][SW-2:0] q_in;
        logic [3:0]         zero_in, full_in;
        logic [MW-1:0]      mag_in;

        if (k == 0) begin : g_first
            assign rem_in  = r_prem;
            assign q_in    = '0;
            assign zero_in = r_pzero;
            assign full_in = r_pfull;
            assign mag_in  = r_pmag;
        end else begin : g_next
            assign rem_in  = r_rrem[k-1];
            assign q_in    = r_rq[k-1];
            assign zero_in = r_rzero[k-1];
            assign full_in = r_rfull[k-1];
            assign mag_in  = r_rmag[k-1];
        end

        always_ff @(posedge i_clk) begin
            logic [SW:0] rem2;
            if (ce) begin
                r_rzero[k] <= zero_in;
                r_rfull[k] <= full_in;
                r_rmag[k]  <= mag_in;
                for (int i = 0; i < 4; i++) begin
                    rem2 = {rem_in[i], 1'b0};
                    if (rem2 >= {1'b0, span}) begin
                        r_rrem[k][i] <= SW'(rem2 - {1'b0, span});
                        r_rq[k][i]   <= {q_in[i][SW-3:0], 1'b1};
                    end else begin
                        r_rrem[k][i] <= rem2[SW-1:0];
                        r_rq[k][i]   <= {q_in[i][SW-3:0], 1'b0};
                    end
                end
            end
        end
    end

    // scale and product for the radial divide
    logic [3:0][SW-1:0]   scaled;
    logic [3:0][SW-1:0]   r_mscl;
    logic [3:0][2*SW-1:0] r_mprod;
    logic [MW-1:0]        r_mmag;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_rzero[RN-1][i]) begin
                scaled[i] = '0;
            end else if (r_rfull[RN-1][i]) begin
                scaled[i] = adz_pkg::FULL_SCALE;
            end else begin
                scaled[i] = {1'b0, r_rq[RN-1][i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_mmag <= r_rmag[RN-1];
            r_mscl <= scaled;
            for (int i = 0; i < 4; i++) begin
                r_mprod[i] <= (2*SW)'(f_abs(r_side[S_RMP].raw[i])) * (2*SW)'(scaled[0]);
            end
        end
    end

    // radial divider: |v| * remapped / magnitude
    logic [3:0][MW-1:0]   r_srem [SN];
    logic [3:0][SW-1:0]   r_slow [SN];
    logic [3:0][SW-1:0]   r_sq2  [SN];
    logic [3:0][SW-1:0]   r_sscl [SN];
    logic [MW-1:0]        r_smag [SN];

    for (genvar k = 0; k < SN; k++) begin : g_scl
        logic [3:0][MW-1:0] rem_in;
        logic [3:0][SW-1:0] low_in, q_in, scl_in;
        logic [MW-1:0]      mag_in;

        if (k == 0) begin : g_first
            for (genvar i = 0; i < 4; i++) begin : g_lane
                assign rem_in[i] = {1'b0, r_mprod[i][2*SW-1:SW]};
                assign low_in[i] = r_mprod[i][SW-1:0];
            end
            assign q_in   = '0;
            assign scl_in = r_mscl;
            assign mag_in = r_mmag;
        end else begin : g_next
            assign rem_in = r_srem[k-1];
            assign low_in = r_slow[k-1];
            assign q_in   = r_sq2[k-1];
            assign scl_in = r_sscl[k-1];
            assign mag_in = r_smag[k-1];
        end

        always_ff @(posedge i_clk) begin
            logic [MW:0] rem2;
            if (ce) begin
                r_sscl[k] <= scl_in;
                r_smag[k] <= mag_in;
                for (int i = 0; i < 4; i++) begin
                    rem2 = {rem_in[i], low_in[i][SW-1]};
                    r_slow[k][i] <= {low_in[i][SW-2:0], 1'b0};
                    if (rem2 >= {1'b0, mag_in}) begin
                        r_srem[k][i] <= MW'(rem2 - {1'b0, mag_in});
                        r_sq2[k][i]  <= {q_in[i][SW-2:0], 1'b1};
                    end else begin
                        r_srem[k][i] <= rem2[MW-1:0];
                        r_sq2[k][i]  <= {q_in[i][SW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // output: pick, clip, restore sign
    logic [3:0][SW-1:0] r_out;

    always_ff @(posedge i_clk) begin
        logic [SW-1:0] val;
        logic [SW-1:0] clip;
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                if (r_side[S_SCL].rad) begin
                    val = (r_smag[SN-1] == '0) ? '0 : r_sq2[SN-1][i];
                end else begin
                    val = r_sscl[SN-1][i];
                end
                clip = (val > adz_pkg::OUT_MAX) ? adz_pkg::OUT_MAX : val;
                if (!r_side[S_SCL].act[i]) begin
                    r_out[i] <= r_side[S_SCL].raw[i];
                end else if (r_side[S_SCL].raw[i][SW-1]) begin
                    r_out[i] <= ~clip + SW'(1);
                end else begin
                    r_out[i] <= clip;
                end
            end
        end
    end

    assign o_x_out = r_out[0];
    assign o_y_out = r_out[1];
    assign o_z_out = r_out[2];
    assign o_w_out = r_out[3];

endmodule

/* rtl/adz_check.sv */
// ----------------------------------------------------------------------------
// adz_check: port-level checks for the dead zone block
// Watches handshakes and pipe behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
module adz_check (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_cfg_valid,
    input logic                     o_cfg_ready,
    input logic [1:0]               i_cfg_index,
    input logic [adz_pkg::SW-1:0]   i_cfg_data,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic [2:0]               i_mode,
    input logic [adz_pkg::SW-1:0]   i_x_in,
    input logic [adz_pkg::SW-1:0]   i_y_in,
    input logic [adz_pkg::SW-1:0]   i_z_in,
    input logic [adz_pkg::SW-1:0]   i_w_in,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [adz_pkg::SW-1:0]   o_x_out,
    input logic [adz_pkg::SW-1:0]   o_y_out,
    input logic [adz_pkg::SW-1:0]   o_z_out,
    input logic [adz_pkg::SW-1:0]   o_w_out
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_x_out) && $stable(o_w_out))
        else $error("result payload changed while stalled");

    // an empty or draining output stage never blocks the input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input blocked with output free");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind axial_radial_dead_zone adz_check u_adz_check (.*);
